@@ src/cifm_pkg.sv @@
// Shared types and constants for the CAN identifier filter and timeout monitor.
// Used by cifm_unit and the top module; no dependencies.
`timescale 1ns / 1ps

package cifm_pkg;

   // default table depth and field widths
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ID_W            = 29;
   localparam int STD_ID_W        = 11;
   localparam int DATA_W          = 64;
   localparam int AGE_W           = 8;
   localparam int KIND_W          = 3;
   localparam int EIDX_W          = 6;
   localparam int DLC_W           = 4;
   localparam int NUM_BYTES       = 8;
   localparam int MAX_EVENTS      = 64;
   localparam int EVCNT_W         = 7;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam int TSIZE_W    = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 4'd1;
   localparam logic [TSIZE_W-1:0]   TABLE_SIZE_RST    = 7'd41;
   localparam logic [AGE_W-1:0]     TIMEOUT_RST       = 8'd50;
   localparam logic [AGE_W-1:0]     AGE_MAX           = 8'd255;

   // request codes
   localparam logic [1:0] REQ_FRAME = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // event codes
   localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
   localparam logic [KIND_W-1:0] EV_ACCEPTED = 3'd1;
   localparam logic [KIND_W-1:0] EV_REJECTED = 3'd2;
   localparam logic [KIND_W-1:0] EV_FRESH    = 3'd3;
   localparam logic [KIND_W-1:0] EV_TIMEOUT  = 3'd4;
   localparam logic [KIND_W-1:0] EV_WRITTEN  = 3'd5;
   localparam logic [KIND_W-1:0] EV_READ     = 3'd6;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MERGE_RD,
      ST_MERGE,
      ST_TICK,
      ST_ACCESS,
      ST_READ
   } st_type;

   // per-entry evaluation results from the shared unit
   typedef struct packed {
      logic              match;
      logic [KIND_W-1:0] kind;
      logic [AGE_W-1:0]  age_next;
      logic              clear;
      logic [DATA_W-1:0] merged;
   } unit_res_type;

endpackage

@@ src/cifm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cifm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/cifm_unit.sv @@
// Shared entry evaluation unit: identifier compare, age update and byte merge.
// Depends on cifm_pkg.
`timescale 1ns / 1ps

module cifm_unit
   import cifm_pkg::*;
(
   input  logic [ID_W-1:0]   key,
   input  logic [ID_W-1:0]   id_entry,
   input  logic [AGE_W-1:0]  age,
   input  logic [AGE_W-1:0]  limit,
   input  logic [DATA_W-1:0] buf_old,
   input  logic [DATA_W-1:0] payload,
   input  logic [DLC_W-1:0]  dlc,
   output unit_res_type      res
);

   logic [DLC_W-1:0] len;

   // clamp length to eight bytes
   assign len = (dlc > DLC_W'(NUM_BYTES)) ? DLC_W'(NUM_BYTES) : dlc;

   always_comb begin
      res       = '0;
      res.match = (id_entry == key);

      // age step for one entry of a tick sweep
      priority if (age == '0) begin
         res.kind     = EV_FRESH;
         res.age_next = AGE_W'(1);
      end else if (age > limit) begin
         res.kind     = EV_TIMEOUT;
         res.age_next = age;
         res.clear    = 1'b1;
      end else begin
         res.kind     = EV_NONE;
         res.age_next = (age == AGE_MAX) ? age : age + AGE_W'(1);
      end

      // replace the low len bytes, keep the rest
      for (int b = 0; b < NUM_BYTES; b++) begin
         res.merged[b*8 +: 8] = (DLC_W'(b) < len) ? payload[b*8 +: 8] : buf_old[b*8 +: 8];
      end
   end

endmodule

@@ src/can_id_filter_timeout_monitor_top.sv @@
// CAN receive mailbox: identifier acceptance filter, buffers and timeout sweep.
// Depends on cifm_pkg, cifm_ram and cifm_unit.
//
//   channel  | ports                          | beat taken when
//   ---------+--------------------------------+-------------------------------
//   request  | start, busy, req_*             | start && !busy
//   result   | rsp_valid, rsp_*               | rsp_valid (one cycle, no stall)
//   config   | csr_valid, csr_ready, csr_*    | csr_valid && csr_ready
//
// Frame: the search reads one identifier per cycle from the table RAM and
// compares it in the shared unit. Tick: one entry per cycle through the age
// RAM port. Each result beat appears in the cycle after its evaluation, from
// the output register. Buffers and ages clear at reset through per-entry
// valid bits, so no clearing pass runs. busy is high while an item is worked
// on; results cannot be held off by the receiver.
`timescale 1ns / 1ps

module can_id_filter_timeout_monitor_top
   import cifm_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [1:0]            req_channel,
   input  logic                  req_extended,
   input  logic [ID_W-1:0]       req_identifier,
   input  logic [EIDX_W-1:0]     req_entry_index,
   input  logic [DLC_W-1:0]      req_dlc,
   input  logic [DATA_W-1:0]     req_payload,
   // result channel
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_event_kind,
   output logic [EIDX_W-1:0]     rsp_event_index,
   output logic [DATA_W-1:0]     rsp_read_data,
   output logic                  rsp_last,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // configuration registers
   logic [TSIZE_W-1:0] table_size_ff;
   logic [AGE_W-1:0]   limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RST;
         limit_ff      <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TABLE_SIZE) begin
            table_size_ff <= csr_wdata[TSIZE_W-1:0];
         end
         if (csr_index == CSR_TIMEOUT_LIMIT) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // state and control registers
   st_type               state_ff, state_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        used_ff, used_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pidx_ff, pidx_in;
   logic                 hold_vld_ff, hold_vld_in;
   logic [KIND_W-1:0]    hold_kind_ff, hold_kind_in;
   logic [AW-1:0]        hold_idx_ff, hold_idx_in;
   logic [EVCNT_W-1:0]   evcnt_ff, evcnt_in;
   logic [TABLE_DEPTH-1:0] bvld_ff, bvld_in;
   logic [TABLE_DEPTH-1:0] avld_ff, avld_in;
   logic                 bvld_q_ff, avld_q_ff;

   // latched request beat
   logic [1:0]           rkind_ff;
   logic [1:0]           chan_ff;
   logic [ID_W-1:0]      key_ff;
   logic [EIDX_W-1:0]    ridx_ff;
   logic [DLC_W-1:0]     dlc_ff;
   logic [DATA_W-1:0]    payload_ff;

   logic accept;
   logic issue;
   logic idx_ok;

   // memory ports
   logic              id_we, id_re;
   logic [AW-1:0]     id_waddr, id_raddr;
   logic [ID_W-1:0]   id_q;
   logic              buf_we, buf_re;
   logic [AW-1:0]     buf_addr;
   logic [DATA_W-1:0] buf_wdata, buf_q, buf_eff;
   logic              age_we, age_re;
   logic [AW-1:0]     age_waddr, age_raddr;
   logic [AGE_W-1:0]  age_wdata, age_q, age_eff;

   // result beat being formed
   logic              emit;
   logic [KIND_W-1:0] emit_kind;
   logic [EIDX_W-1:0] emit_idx;
   logic [DATA_W-1:0] emit_data;
   logic              emit_last;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [EIDX_W-1:0] rsp_idx_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   unit_res_type ures;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign issue  = (ptr_ff < used_ff);
   assign idx_ok = (32'(ridx_ff) < TABLE_DEPTH);
   assign used_in = (32'(table_size_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(table_size_ff);

   // unwritten buffers and ages read as zero
   assign buf_eff = bvld_q_ff ? buf_q : '0;
   assign age_eff = avld_q_ff ? age_q : '0;

   cifm_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (id_waddr),
      .wdata (key_ff),
      .re    (id_re),
      .raddr (id_raddr),
      .rdata (id_q)
   );

   cifm_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_buf_ram (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_addr),
      .wdata (buf_wdata),
      .re    (buf_re),
      .raddr (buf_addr),
      .rdata (buf_q)
   );

   cifm_ram #(.WIDTH(AGE_W), .DEPTH(TABLE_DEPTH)) u_age_ram (
      .clock (clock),
      .we    (age_we),
      .waddr (age_waddr),
      .wdata (age_wdata),
      .re    (age_re),
      .raddr (age_raddr),
      .rdata (age_q)
   );

   cifm_unit u_unit (
      .key      (key_ff),
      .id_entry (id_q),
      .age      (age_eff),
      .limit    (limit_ff),
      .buf_old  (buf_eff),
      .payload  (payload_ff),
      .dlc      (dlc_ff),
      .res      (ures)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_FRAME: state_in = ST_SEARCH;
                  REQ_TICK:  state_in = ST_TICK;
                  REQ_WRITE,
                  REQ_READ:  state_in = ST_ACCESS;
               endcase
            end
         end
         ST_SEARCH: begin
            priority if (pend_ff && ures.match) begin
               state_in = ST_MERGE_RD;
            end else if (!issue) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_MERGE_RD: state_in = ST_MERGE;
         ST_MERGE:    state_in = ST_IDLE;
         ST_TICK: begin
            if (!issue && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCESS: begin
            state_in = (idx_ok && rkind_ff == REQ_READ) ? ST_READ : ST_IDLE;
         end
         ST_READ:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath control and result beats
   always_comb begin
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      hold_vld_in  = hold_vld_ff;
      hold_kind_in = hold_kind_ff;
      hold_idx_in  = hold_idx_ff;
      evcnt_in     = evcnt_ff;
      bvld_in      = bvld_ff;
      avld_in      = avld_ff;
      id_we        = 1'b0;
      id_re        = 1'b0;
      id_waddr     = AW'(ridx_ff);
      id_raddr     = ptr_ff[AW-1:0];
      buf_we       = 1'b0;
      buf_re       = 1'b0;
      buf_addr     = pidx_ff;
      buf_wdata    = ures.merged;
      age_we       = 1'b0;
      age_re       = 1'b0;
      age_waddr    = pidx_ff;
      age_raddr    = ptr_ff[AW-1:0];
      age_wdata    = ures.age_next;
      emit         = 1'b0;
      emit_kind    = EV_NONE;
      emit_idx     = '0;
      emit_data    = '0;
      emit_last    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ptr_in      = '0;
            hold_vld_in = 1'b0;
            evcnt_in    = '0;
         end
         // one identifier read per cycle, compared in the next cycle
         ST_SEARCH: begin
            id_re   = issue;
            pend_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            if (issue && !(pend_ff && ures.match)) begin
               pidx_in = ptr_ff[AW-1:0];
            end
            if (!(pend_ff && ures.match) && !issue) begin
               emit      = 1'b1;
               emit_kind = EV_REJECTED;
               emit_last = 1'b1;
            end
         end
         ST_MERGE_RD: begin
            buf_re = 1'b1;
         end
         // byte merge into the matched buffer; channels 0 and 1 also clear its age
         ST_MERGE: begin
            buf_we           = 1'b1;
            bvld_in[pidx_ff] = 1'b1;
            if (!chan_ff[1]) begin
               age_we           = 1'b1;
               age_wdata        = '0;
               avld_in[pidx_ff] = 1'b1;
            end
            emit      = 1'b1;
            emit_kind = EV_ACCEPTED;
            emit_idx  = EIDX_W'(pidx_ff);
            emit_last = 1'b1;
         end
         // age sweep; the latest event waits in the hold register
         ST_TICK: begin
            age_re  = issue;
            pend_in = issue;
            if (issue) begin
               ptr_in  = ptr_ff + CW'(1);
               pidx_in = ptr_ff[AW-1:0];
            end
            if (pend_ff) begin
               age_we           = 1'b1;
               avld_in[pidx_ff] = 1'b1;
               if (ures.clear) begin
                  bvld_in[pidx_ff] = 1'b0;
               end
               if (ures.kind != EV_NONE && 32'(evcnt_ff) < MAX_EVENTS) begin
                  if (hold_vld_ff) begin
                     emit      = 1'b1;
                     emit_kind = hold_kind_ff;
                     emit_idx  = EIDX_W'(hold_idx_ff);
                  end
                  hold_vld_in  = 1'b1;
                  hold_kind_in = ures.kind;
                  hold_idx_in  = pidx_ff;
                  evcnt_in     = evcnt_ff + EVCNT_W'(1);
               end
            end else if (!issue) begin
               emit      = 1'b1;
               emit_kind = hold_vld_ff ? hold_kind_ff : EV_NONE;
               emit_idx  = hold_vld_ff ? EIDX_W'(hold_idx_ff) : '0;
               emit_last = 1'b1;
            end
         end
         // table write or buffer read by index
         ST_ACCESS: begin
            buf_addr = AW'(ridx_ff);
            priority if (!idx_ok) begin
               emit      = 1'b1;
               emit_kind = EV_REJECTED;
               emit_idx  = ridx_ff;
               emit_last = 1'b1;
            end else if (rkind_ff == REQ_WRITE) begin
               id_we     = 1'b1;
               emit      = 1'b1;
               emit_kind = EV_WRITTEN;
               emit_idx  = ridx_ff;
               emit_last = 1'b1;
            end else begin
               buf_re = 1'b1;
            end
         end
         ST_READ: begin
            emit      = 1'b1;
            emit_kind = EV_READ;
            emit_idx  = ridx_ff;
            emit_data = buf_eff;
            emit_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_ff     <= 1'b0;
         hold_vld_ff <= 1'b0;
         evcnt_ff    <= '0;
         bvld_ff     <= '0;
         avld_ff     <= '0;
         ptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         hold_vld_ff <= hold_vld_in;
         evcnt_ff    <= evcnt_in;
         bvld_ff     <= bvld_in;
         avld_ff     <= avld_in;
         ptr_ff      <= ptr_in;
         rsp_valid_ff <= emit;
      end
   end

   // payload registers; table writes keep the full identifier
   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      hold_kind_ff <= hold_kind_in;
      hold_idx_ff  <= hold_idx_in;
      bvld_q_ff    <= bvld_ff[buf_addr];
      avld_q_ff    <= avld_ff[age_raddr];
      rsp_kind_ff  <= emit_kind;
      rsp_idx_ff   <= emit_idx;
      rsp_data_ff  <= emit_data;
      rsp_last_ff  <= emit_last;
      if (accept) begin
         rkind_ff   <= req_type;
         chan_ff    <= req_channel;
         key_ff     <= (req_extended || req_type != REQ_FRAME) ? req_identifier
                                    : ID_W'(req_identifier[STD_ID_W-1:0]);
         ridx_ff    <= req_entry_index;
         dlc_ff     <= req_dlc;
         payload_ff <= req_payload;
         used_ff    <= used_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_index = rsp_idx_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   // a merge always follows the buffer read of the matched entry
   a_merge_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ($past(state_ff) == ST_MERGE_RD))
      else $error("merge without preceding buffer read");

   // only read beats carry buffer data
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_READ) |-> (rsp_read_data == '0))
      else $error("read data on a non-read result");

   // event count never passes the per-tick limit
   a_evcnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(evcnt_ff) <= MAX_EVENTS)
      else $error("tick event count overflow");

endmodule

@@ tb/can_id_filter_timeout_monitor_top_tb.sv @@
// Self-checking testbench for the CAN identifier filter and timeout monitor.
// Depends on cifm_pkg and can_id_filter_timeout_monitor_top; a mailbox model
// in a small checker class predicts every result beat.
`timescale 1ns / 1ps

module can_id_filter_timeout_monitor_top_tb;
   import cifm_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 43;
   localparam int NUM_PHASES   = 8;
   localparam int MAX_REPORTS  = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'hF;
   localparam logic [ID_W-1:0]      ID_ONES   = {ID_W{1'b1}};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [EIDX_W-1:0] entry;
      logic [DATA_W-1:0] data;
      logic              last;
   } mbx_event_type;

   // mailbox model and store of awaited result beats
   class mailbox_checker;
      logic [ID_W-1:0]    id_table [DEPTH];
      logic [DATA_W-1:0]  buffer [DEPTH];
      logic [AGE_W-1:0]   age [DEPTH];
      logic [TSIZE_W-1:0] table_size;
      logic [AGE_W-1:0]   timeout_limit;
      mbx_event_type      awaited [$];
      int                 errors;

      function new();
         table_size    = TABLE_SIZE_RST;
         timeout_limit = TIMEOUT_RST;
         errors        = 0;
         for (int i = 0; i < DEPTH; i++) begin
            id_table[i] = '0;
            buffer[i]   = '0;
            age[i]      = '0;
         end
      endfunction

      function int entries_in_use();
         return (table_size > DEPTH) ? DEPTH : int'(table_size);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_TABLE_SIZE) begin
            table_size = data[TSIZE_W-1:0];
         end else if (idx == CSR_TIMEOUT_LIMIT) begin
            timeout_limit = data;
         end
      endfunction

      function void push_event(logic [KIND_W-1:0] kind, logic [EIDX_W-1:0] entry,
                               logic [DATA_W-1:0] data, logic last);
         mbx_event_type ev;
         ev.kind  = kind;
         ev.entry = entry;
         ev.data  = data;
         ev.last  = last;
         awaited.push_back(ev);
      endfunction

      // update the mailbox for one accepted request and queue its results
      function void note_request(logic [1:0] kind, logic [1:0] chan, logic ext,
                                 logic [ID_W-1:0] ident, logic [EIDX_W-1:0] entry,
                                 logic [DLC_W-1:0] dlc, logic [DATA_W-1:0] payload);
         int                used;
         int                hit;
         int                len;
         int                n;
         int                i;
         logic [ID_W-1:0]   key;
         logic [DATA_W-1:0] mask;
         logic [KIND_W-1:0] k;
         logic [KIND_W-1:0] ev_kind [MAX_EVENTS];
         logic [EIDX_W-1:0] ev_entry [MAX_EVENTS];
         used = entries_in_use();
         hit  = -1;
         n    = 0;
         case (kind)
            REQ_FRAME: begin
               // standard frames compare only the low 11 bits
               key = ext ? ident : {{(ID_W-STD_ID_W){1'b0}}, ident[STD_ID_W-1:0]};
               for (i = 0; i < used && hit < 0; i++) begin
                  if (id_table[i] == key) hit = i;
               end
               if (hit >= 0) begin
                  len  = (dlc > NUM_BYTES) ? NUM_BYTES : int'(dlc);
                  mask = (len >= NUM_BYTES) ? '1 : (64'd1 << (8 * len)) - 64'd1;
                  buffer[hit] = (buffer[hit] & ~mask) | (payload & mask);
                  if (chan <= 2'd1) age[hit] = '0;
                  push_event(EV_ACCEPTED, hit[EIDX_W-1:0], '0, 1'b1);
               end else begin
                  push_event(EV_REJECTED, '0, '0, 1'b1);
               end
            end
            REQ_TICK: begin
               // sweep in index order: fresh, stale, or one tick older
               for (i = 0; i < used; i++) begin
                  k = EV_NONE;
                  if (age[i] == '0) begin
                     k      = EV_FRESH;
                     age[i] = 8'd1;
                  end else if (age[i] > timeout_limit) begin
                     k         = EV_TIMEOUT;
                     buffer[i] = '0;
                  end else if (age[i] != AGE_MAX) begin
                     age[i] = age[i] + 8'd1;
                  end
                  if (k != EV_NONE && n < MAX_EVENTS) begin
                     ev_kind[n]  = k;
                     ev_entry[n] = i[EIDX_W-1:0];
                     n++;
                  end
               end
               if (n == 0) push_event(EV_NONE, '0, '0, 1'b1);
               for (i = 0; i < n; i++) begin
                  push_event(ev_kind[i], ev_entry[i], '0, i == n - 1);
               end
            end
            REQ_WRITE: begin
               id_table[entry] = ident;
               push_event(EV_WRITTEN, entry, '0, 1'b1);
            end
            REQ_READ: begin
               push_event(EV_READ, entry, buffer[entry], 1'b1);
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      // compare one result beat with the oldest awaited one
      task check_result(logic [KIND_W-1:0] kind, logic [EIDX_W-1:0] entry,
                        logic [DATA_W-1:0] data, logic last);
         mbx_event_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result kind %0d entry %0d", kind, entry));
         end else begin
            want = awaited.pop_front();
            if (kind !== want.kind)
               report($sformatf("event_kind %0d, wanted %0d", kind, want.kind));
            if (entry !== want.entry)
               report($sformatf("event_index %0d, wanted %0d", entry, want.entry));
            if (data !== want.data)
               report($sformatf("read_data %h, wanted %h", data, want.data));
            if (last !== want.last)
               report($sformatf("last %b, wanted %b", last, want.last));
         end
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  start           = 1'b0;
   logic                  busy;
   logic [1:0]            req_type        = '0;
   logic [1:0]            req_channel     = '0;
   logic                  req_extended    = 1'b0;
   logic [ID_W-1:0]       req_identifier  = '0;
   logic [EIDX_W-1:0]     req_entry_index = '0;
   logic [DLC_W-1:0]      req_dlc         = '0;
   logic [DATA_W-1:0]     req_payload     = '0;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_event_kind;
   logic [EIDX_W-1:0]     rsp_event_index;
   logic [DATA_W-1:0]     rsp_read_data;
   logic                  rsp_last;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   mailbox_checker mbx;
   bit             steady = 1'b0;
   int             quiet_cycles = 0;

   can_id_filter_timeout_monitor_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_extended    (req_extended),
      .req_identifier  (req_identifier),
      .req_entry_index (req_entry_index),
      .req_dlc         (req_dlc),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_index (rsp_event_index),
      .rsp_read_data   (rsp_read_data),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result beats are taken at the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         mbx.check_result(rsp_event_kind, rsp_event_index, rsp_read_data, rsp_last);
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one request beat, after an optional random idle gap
   task automatic send_req(logic [1:0] kind, logic [1:0] chan, logic ext,
                           logic [ID_W-1:0] ident, logic [EIDX_W-1:0] entry,
                           logic [DLC_W-1:0] dlc, logic [DATA_W-1:0] payload);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 16) gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_channel     <= chan;
      req_extended    <= ext;
      req_identifier  <= ident;
      req_entry_index <= entry;
      req_dlc         <= dlc;
      req_payload     <= payload;
      do @(posedge clock); while (busy !== 1'b0);
      mbx.note_request(kind, chan, ext, ident, entry, dlc, payload);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (mbx.pending() != 0) @(posedge clock);
   endtask

   // one register beat; the caller lowers csr_valid
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mbx.write_reg(idx, data);
   endtask

   // new settings once the block has gone idle
   task automatic configure(logic [TSIZE_W-1:0] size, logic [AGE_W-1:0] limit);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(CSR_TABLE_SIZE, {1'b0, size});
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      write_csr(CSR_TIMEOUT_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   // frames, most of which hit the table, plus ticks, table writes and reads
   task automatic random_item();
      int                pick;
      int                used;
      logic [1:0]        kind;
      logic [1:0]        chan;
      logic              ext;
      logic [ID_W-1:0]   ident;
      logic [ID_W-1:0]   stored;
      logic [EIDX_W-1:0] entry;
      logic [DLC_W-1:0]  dlc;
      logic [DATA_W-1:0] payload;
      pick    = $urandom_range(99);
      chan    = (pick < 35) ? 2'd0 : (pick < 70) ? 2'd1 : (pick < 85) ? 2'd2 : 2'd3;
      ext     = 1'($urandom_range(1));
      ident   = ID_W'($urandom);
      entry   = EIDX_W'($urandom);
      dlc     = DLC_W'($urandom);
      payload = {$urandom, $urandom};
      used    = mbx.entries_in_use();
      pick    = $urandom_range(99);
      if (pick < 45) begin
         kind = REQ_FRAME;
         if (used > 0 && $urandom_range(99) < 75) begin
            stored = mbx.id_table[$urandom_range(used - 1)];
            if (!ext && stored < (1 << STD_ID_W)) begin
               // upper identifier bits stay random on a standard frame
               ident[STD_ID_W-1:0] = stored[STD_ID_W-1:0];
            end else begin
               ext   = 1'b1;
               ident = stored;
            end
         end
      end else if (pick < 70) begin
         kind = REQ_TICK;
      end else if (pick < 80) begin
         kind = REQ_WRITE;
         pick = $urandom_range(99);
         if (pick < 50) ident = ID_W'($urandom_range((1 << STD_ID_W) - 1));
         else if (pick < 70) ident = mbx.id_table[$urandom_range(DEPTH - 1)];
      end else begin
         kind = REQ_READ;
      end
      send_req(kind, chan, ext, ident, entry, dlc, payload);
   endtask

   initial begin
      logic [ID_W-1:0]    value;
      logic [TSIZE_W-1:0] size;
      logic [AGE_W-1:0]   limit;
      mbx = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every entry in use reports fresh
      send_req(REQ_TICK, 2'd0, 1'b0, '0, '0, '0, '0);

      // empty table: a frame is rejected, a tick gives a single none
      configure(7'd0, TIMEOUT_RST);
      send_req(REQ_FRAME, 2'd1, 1'b1, 29'h155, '0, 4'd8, '1);
      send_req(REQ_TICK, 2'd0, 1'b0, '0, '0, '0, '0);

      // load the whole table, with extremes and a duplicate identifier
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       value = '0;
            1:       value = 29'h7FF;
            2:       value = ID_ONES;
            6:       value = mbx.id_table[4];
            default: value = (i % 3 == 0) ? ID_W'($urandom_range(2047)) : ID_W'($urandom);
         endcase
         send_req(REQ_WRITE, 2'($urandom), 1'($urandom), value, EIDX_W'(i),
                  DLC_W'($urandom), {$urandom, $urandom});
      end

      // directed: dlc limits, standard masking, channels, first match, timeouts
      configure(7'd64, 8'd0);
      send_req(REQ_FRAME, 2'd0, 1'b1, ID_ONES, '0, 4'd8, '1);
      send_req(REQ_FRAME, 2'd1, 1'b0, ID_ONES, '0, 4'd15, 64'h0123_4567_89AB_CDEF);
      send_req(REQ_FRAME, 2'd2, 1'b0, 29'h1555_5800, '0, 4'd0, '1);
      send_req(REQ_FRAME, 2'd3, 1'b1, '0, '1, 4'd3, {$urandom, $urandom});
      send_req(REQ_FRAME, 2'd0, 1'b1, mbx.id_table[6], '0, 4'd5, {$urandom, $urandom});
      send_req(REQ_FRAME, 2'd1, 1'b1, 29'h0ABC_DEF1, '0, 4'd4, {$urandom, $urandom});
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd2, '0, '0);
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd1, '0, '0);
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd0, '0, '0);
      send_req(REQ_TICK, 2'd0, 1'b0, '0, '0, '0, '0);
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd2, '0, '0);
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd40, '0, '0);
      send_req(REQ_WRITE, 2'd0, 1'b0, ID_ONES, 6'd63, '0, '0);
      send_req(REQ_FRAME, 2'd0, 1'b1, ID_ONES, '0, 4'd1, '1);
      send_req(REQ_TICK, 2'd1, 1'b1, ID_ONES, '1, '1, '1);
      send_req(REQ_TICK, 2'd0, 1'b0, '0, '0, '0, '0);
      send_req(REQ_READ, 2'd0, 1'b0, '0, 6'd63, '0, '0);

      // random phases over a spread of table sizes and timeout limits
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       begin size = 7'd64;  limit = 8'd3;   end
            1:       begin size = 7'd1;   limit = 8'd0;   end
            2:       begin size = 7'd20;  limit = 8'd254; end
            3:       begin size = 7'd100; limit = 8'd5;   end
            4:       begin size = 7'd0;   limit = 8'd10;  end
            5:       begin size = 7'd37;  limit = 8'd255; end
            6:       begin size = 7'd64;  limit = 8'd1;   end
            default: begin size = 7'd10;  limit = 8'd2;   end
         endcase
         configure(size, limit);
         // one phase runs with no random idle gaps between requests
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n > 0 && $urandom_range(99) < 4) wait_drained();
            random_item();
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mbx.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/cifm_pkg.sv
src/cifm_ram.sv
src/cifm_unit.sv
src/can_id_filter_timeout_monitor_top.sv
tb/can_id_filter_timeout_monitor_top_tb.sv
